[rtl/cap_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cap_pkg
// Types, constants and register codes shared by the chunk access pattern
// classifier modules.
// ----------------------------------------------------------------------------
package cap_pkg;

  // Configuration port geometry.
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 3;

  // Register indexes (byte address divided by four).
  localparam logic [IdxW-1:0] RegInactiveLimit = 3'd0;
  localparam logic [IdxW-1:0] RegRwRatio       = 3'd1;
  localparam logic [IdxW-1:0] RegSeqBytesRatio = 3'd2;
  localparam logic [IdxW-1:0] RegSeqCountRatio = 3'd3;
  localparam logic [IdxW-1:0] RegIntensive     = 3'd4;

  // Register reset values.
  localparam logic [31:0] InactiveLimitRst = 32'd2;
  localparam logic [16:0] RwRatioRst       = 17'd52429;
  localparam logic [16:0] SeqBytesRatioRst = 17'd32768;
  localparam logic [16:0] SeqCountRatioRst = 17'd32768;
  localparam logic [15:0] IntensiveRst     = 16'd256;

  // Sequencing of the shared datapath units.
  localparam int unsigned DivSteps = 32;
  localparam int unsigned CntW     = $clog2(DivSteps);
  localparam int unsigned MulSteps = 5;
  localparam int unsigned MulSelW  = 3;
  localparam int unsigned ProdW    = 49;

  // Target tiers.
  localparam logic [1:0] TierHdd = 2'd0;
  localparam logic [1:0] TierSsd = 2'd1;
  localparam logic [1:0] TierScm = 2'd2;

  // Base pattern codes; the read, write or hybrid label is added on top.
  localparam logic [3:0] CodeNone     = 4'd0;
  localparam logic [3:0] CodeInactive = 4'd1;
  localparam logic [3:0] CodeSeqInt   = 4'd4;
  localparam logic [3:0] CodeSeqLess  = 4'd7;
  localparam logic [3:0] CodeRandInt  = 4'd10;
  localparam logic [3:0] CodeRandLess = 4'd13;

  // Read, write and hybrid labels.
  localparam logic [1:0] LabRead   = 2'd0;
  localparam logic [1:0] LabWrite  = 2'd1;
  localparam logic [1:0] LabHybrid = 2'd2;

  // Products formed by the shared multiplier, in issue order.
  typedef enum logic [MulSelW-1:0] {
    MUL_RW     = 3'd0,
    MUL_SC     = 3'd1,
    MUL_SB_LO  = 3'd2,
    MUL_SB_HI  = 3'd3,
    MUL_INT    = 3'd4
  } mul_sel_e;

  typedef struct packed {
    logic [31:0] total_requests;
    logic [31:0] read_requests;
    logic [31:0] write_requests;
    logic [39:0] total_size;
    logic [39:0] seq_size;
    logic [31:0] seq_requests;
    logic        ever_accessed;
    logic [31:0] window_requests;
    logic [31:0] window_chunks;
    logic        last_chunk;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  pattern_code;
    logic [1:0]  target_tier;
    logic [31:0] count_non_access;
    logic [31:0] count_inactive;
    logic [31:0] count_seq_intensive;
    logic [31:0] count_seq_less;
    logic [31:0] count_rand_intensive;
    logic [31:0] count_rand_less;
    logic        window_done;
  } out_item_t;

  typedef struct packed {
    logic [31:0] inactive_limit;
    logic [16:0] rw_ratio_limit;
    logic [16:0] seq_bytes_ratio_limit;
    logic [16:0] seq_count_ratio_limit;
    logic [15:0] intensive_factor;
  } cfg_t;

  typedef struct packed {
    logic [31:0] non_access;
    logic [31:0] inactive;
    logic [31:0] seq_int;
    logic [31:0] seq_less;
    logic [31:0] rand_int;
    logic [31:0] rand_less;
  } counts_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_in;
    logic     div_step;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     load_out;
  } cmd_t;

endpackage
`default_nettype wire

[rtl/cap_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cap_regs
// Configuration registers behind a simple APB-style slave port.
// ----------------------------------------------------------------------------
module cap_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [cap_pkg::AddrW-1:0] paddr,
  input  wire logic [cap_pkg::DataW-1:0] pwdata,
  output logic      [cap_pkg::DataW-1:0] prdata,
  output logic                           pready,
  output cap_pkg::cfg_t                  cfg_o
);
  import cap_pkg::*;

  cfg_t            cfg_q;
  logic [IdxW-1:0] idx;
  logic            wr_en;

  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inactive_limit        <= InactiveLimitRst;
      cfg_q.rw_ratio_limit        <= RwRatioRst;
      cfg_q.seq_bytes_ratio_limit <= SeqBytesRatioRst;
      cfg_q.seq_count_ratio_limit <= SeqCountRatioRst;
      cfg_q.intensive_factor      <= IntensiveRst;
    end else if (wr_en) begin
      unique case (idx)
        RegInactiveLimit: cfg_q.inactive_limit        <= pwdata;
        RegRwRatio:       cfg_q.rw_ratio_limit        <= pwdata[16:0];
        RegSeqBytesRatio: cfg_q.seq_bytes_ratio_limit <= pwdata[16:0];
        RegSeqCountRatio: cfg_q.seq_count_ratio_limit <= pwdata[16:0];
        RegIntensive:     cfg_q.intensive_factor      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegInactiveLimit: prdata = cfg_q.inactive_limit;
      RegRwRatio:       prdata = {15'd0, cfg_q.rw_ratio_limit};
      RegSeqBytesRatio: prdata = {15'd0, cfg_q.seq_bytes_ratio_limit};
      RegSeqCountRatio: prdata = {15'd0, cfg_q.seq_count_ratio_limit};
      RegIntensive:     prdata = {16'd0, cfg_q.intensive_factor};
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/cap_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cap_dp
// Datapath: input capture, serial divider, shared multiplier with share
// compares, classification, window counters and result register.
// ----------------------------------------------------------------------------
module cap_dp (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cap_pkg::cmd_t     cmd_i,
  input  wire cap_pkg::cfg_t     cfg_i,
  input  wire cap_pkg::in_item_t in_data_i,
  output cap_pkg::out_item_t out_data_o
);
  import cap_pkg::*;

  in_item_t    in_q;
  logic [31:0] quo_q, rem_q;
  logic [32:0] trial;
  logic [31:0] mean;

  logic [16:0]      mul_a;
  logic [31:0]      mul_b;
  logic [ProdW-1:0] prod_q;
  mul_sel_e         psel_q;
  logic             pvld_q;
  logic [ProdW-1:0] sb_lo_q;
  logic [56:0]      sb_full;

  logic rd_ok_q, wr_ok_q, sc_ok_q, sb_ok_q, int_ok_q;

  counts_t   cnt_q, cnt_next;
  out_item_t out_q;
  logic [1:0] lab;
  logic [3:0] base;
  logic [1:0] tier;
  logic       seq;

  // Restoring division, one quotient bit per step.
  assign trial = {rem_q, quo_q[31]} - {1'b0, in_q.window_chunks};
  assign mean  = (in_q.window_chunks == 32'd0) ? 32'd0 : quo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q  <= in_data_i;
      quo_q <= in_data_i.window_requests;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= {rem_q[30:0], quo_q[31]};
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_RW: begin
        mul_a = cfg_i.rw_ratio_limit;
        mul_b = in_q.total_requests;
      end
      MUL_SC: begin
        mul_a = cfg_i.seq_count_ratio_limit;
        mul_b = in_q.total_requests;
      end
      MUL_SB_LO: begin
        mul_a = cfg_i.seq_bytes_ratio_limit;
        mul_b = in_q.total_size[31:0];
      end
      MUL_SB_HI: begin
        mul_a = cfg_i.seq_bytes_ratio_limit;
        mul_b = {24'd0, in_q.total_size[39:32]};
      end
      MUL_INT: begin
        mul_a = {1'b0, cfg_i.intensive_factor};
        mul_b = mean;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
    end else begin
      pvld_q <= cmd_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
      psel_q <= cmd_i.mul_sel;
    end
  end

  // The byte share limit times a 40-bit size, from its two partial products.
  assign sb_full = {8'd0, sb_lo_q} + {prod_q[24:0], 32'd0};

  // A zero denominator reads as share zero: the test passes only for limit zero.
  always_ff @(posedge clk_i) begin
    if (pvld_q) begin
      unique case (psel_q)
        MUL_RW: begin
          if (in_q.total_requests == 32'd0) begin
            rd_ok_q <= (cfg_i.rw_ratio_limit == 17'd0);
            wr_ok_q <= (cfg_i.rw_ratio_limit == 17'd0);
          end else begin
            rd_ok_q <= ({1'b0, in_q.read_requests, 16'd0} >= prod_q);
            wr_ok_q <= ({1'b0, in_q.write_requests, 16'd0} >= prod_q);
          end
        end
        MUL_SC: begin
          if (in_q.total_requests == 32'd0) begin
            sc_ok_q <= (cfg_i.seq_count_ratio_limit == 17'd0);
          end else begin
            sc_ok_q <= ({1'b0, in_q.seq_requests, 16'd0} >= prod_q);
          end
        end
        MUL_SB_LO: begin
          sb_lo_q <= prod_q;
        end
        MUL_SB_HI: begin
          if (in_q.total_size == 40'd0) begin
            sb_ok_q <= (cfg_i.seq_bytes_ratio_limit == 17'd0);
          end else begin
            sb_ok_q <= ({1'b0, in_q.seq_size, 16'd0} >= sb_full);
          end
        end
        MUL_INT: begin
          int_ok_q <= ({9'd0, in_q.total_requests, 8'd0} >= prod_q);
        end
        default: ;
      endcase
    end
  end

  // Classification of the captured chunk.
  always_comb begin
    priority if (rd_ok_q) begin
      lab = LabRead;
    end else if (wr_ok_q) begin
      lab = LabWrite;
    end else begin
      lab = LabHybrid;
    end
  end

  assign seq = sb_ok_q && sc_ok_q;

  always_comb begin
    cnt_next = cnt_q;
    priority if (in_q.total_requests == 32'd0) begin
      base = CodeNone;
      tier = TierHdd;
      if (in_q.ever_accessed) begin
        cnt_next.non_access = cnt_q.non_access + 32'd1;
      end
    end else if (in_q.total_requests < cfg_i.inactive_limit) begin
      base = CodeInactive;
      tier = TierHdd;
      cnt_next.inactive = cnt_q.inactive + 32'd1;
    end else if (seq && int_ok_q) begin
      base = CodeSeqInt;
      tier = (lab == LabRead) ? TierSsd : TierScm;
      cnt_next.seq_int = cnt_q.seq_int + 32'd1;
    end else if (seq) begin
      base = CodeSeqLess;
      tier = TierHdd;
      cnt_next.seq_less = cnt_q.seq_less + 32'd1;
    end else if (int_ok_q) begin
      base = CodeRandInt;
      tier = (lab == LabRead) ? TierSsd : TierScm;
      cnt_next.rand_int = cnt_q.rand_int + 32'd1;
    end else begin
      base = CodeRandLess;
      tier = TierSsd;
      cnt_next.rand_less = cnt_q.rand_less + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load_out) begin
      cnt_q <= in_q.last_chunk ? '0 : cnt_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.pattern_code <= (in_q.total_requests == 32'd0) ? CodeNone : base + {2'd0, lab};
      out_q.target_tier  <= tier;
      out_q.window_done  <= in_q.last_chunk;
      if (in_q.last_chunk) begin
        out_q.count_non_access     <= cnt_next.non_access;
        out_q.count_inactive       <= cnt_next.inactive;
        out_q.count_seq_intensive  <= cnt_next.seq_int;
        out_q.count_seq_less       <= cnt_next.seq_less;
        out_q.count_rand_intensive <= cnt_next.rand_int;
        out_q.count_rand_less      <= cnt_next.rand_less;
      end else begin
        out_q.count_non_access     <= '0;
        out_q.count_inactive       <= '0;
        out_q.count_seq_intensive  <= '0;
        out_q.count_seq_less       <= '0;
        out_q.count_rand_intensive <= '0;
        out_q.count_rand_less      <= '0;
      end
    end
  end

  assign out_data_o = out_q;

endmodule
`default_nettype wire

[rtl/cap_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cap_ctrl
// Controller: sequences capture, division, multiplies and result hand-over.
// ----------------------------------------------------------------------------
module cap_ctrl (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output cap_pkg::cmd_t cmd_o
);
  import cap_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_EVAL,
    ST_FIN
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    cmd_o.load_in   = 1'b0;
    cmd_o.div_step  = 1'b0;
    cmd_o.mul_en    = 1'b0;
    cmd_o.mul_sel   = mul_sel_e'(cnt_q[MulSelW-1:0]);
    cmd_o.load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cnt_d         = '0;
          state_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          cnt_d   = '0;
          state_d = ST_MUL;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        if (cnt_q == CntW'(MulSteps - 1)) begin
          state_d = ST_EVAL;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_EVAL: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DIV && !in_ready_o))
    else $error("accepted request did not start the divider");

  a_fin_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && (!out_valid_q || out_ready_i)) |=> out_valid_q)
    else $error("finished result was not presented");

  a_eval_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> $past(state_q == ST_MUL && cnt_q == CntW'(MulSteps - 1)))
    else $error("evaluation reached without the last multiply");

endmodule
`default_nettype wire

[rtl/chunk_access_pattern_classifier_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chunk_access_pattern_classifier_core
// Classifies one chunk's window statistics per request into a pattern code
// and a target tier, and reports the window's category counters.
// ----------------------------------------------------------------------------
// Each accepted request is captured; the serial divider then forms the
// window's mean requests per accessed chunk, the shared 17x32 multiplier
// forms the read/write share, sequential count share, two halves of the
// sequential byte share and intensity products, and after an evaluation
// step the result register is loaded. The block takes a new request while
// the previous result still waits in the output register; it holds in its
// final cycle only if that result has still not been taken.
// Configuration registers sit at byte addresses 0, 4, 8, 12 and 16 in the
// order inactive limit, read/write share limit, sequential byte share limit,
// sequential count share limit and intensive factor; they should be written
// only while no request is in flight. On the request flagged as the last
// chunk, the result carries the window's counters, that chunk included, and
// the counters then restart from zero; on other requests the counter fields
// read zero.
// ----------------------------------------------------------------------------
module chunk_access_pattern_classifier_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire cap_pkg::in_item_t         in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output cap_pkg::out_item_t             out_data_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [cap_pkg::AddrW-1:0] paddr,
  input  wire logic [cap_pkg::DataW-1:0] pwdata,
  output logic      [cap_pkg::DataW-1:0] prdata,
  output logic                           pready
);
  import cap_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  // Regs: read at any time; user writes only in idle periods, unchecked.
  cap_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The controller owns both handshakes and steps the datapath by command.
  cap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // The datapath holds the captured request, the arithmetic, the window
  // counters and the result register.
  cap_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire
